FILE: sv/bsf_pkg.sv
// shared types and constants of the bit-aligned sync byte framer
// no dependencies
package bsf_pkg;

    localparam int RAW_W = 8;
    localparam int LEN_W = 10;
    localparam int POS_W = 14;
    localparam int EMIT_W = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;
    localparam int RESULT_SLOTS = 3;

    localparam int DEF_MAX_AREA_BYTES = 2048;
    localparam int DEF_LENGTH_SLACK = 100;

    localparam logic [LEN_W-1:0] RST_ADDRESS_LENGTH = LEN_W'(16);
    localparam logic [LEN_W-1:0] RST_DATA_LENGTH = LEN_W'(512);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AREA_SELECT    = 3'd0,
        CFG_ADDRESS_LENGTH = 3'd1,
        CFG_ADDRESS_SYNC   = 3'd2,
        CFG_DATA_LENGTH    = 3'd3,
        CFG_DATA_SYNC      = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LENGTH   = 2'd1,
        ST_NO_SYNC  = 2'd2,
        ST_TOO_LESS = 2'd3
    } area_status_t;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [RAW_W-1:0] raw_byte;
        logic             final_byte;
    } in_item_t;

    typedef struct packed {
        logic             kind;
        logic [RAW_W-1:0] aligned_byte;
        logic [1:0]       area_status;
        logic [POS_W-1:0] sync_bit_position;
        logic             run_end;
    } out_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic [RAW_W-1:0] pattern;
    } area_cfg_t;

    // slot 0 and 1 data beats, slot 2 status beat
    typedef struct packed {
        logic [RESULT_SLOTS-1:0]            valid;
        out_item_t [RESULT_SLOTS-1:0]       item;
    } result_set_t;

endpackage

FILE: sv/bsf_stream_if.sv
// valid/ready stream channel carrying one payload per beat
// depends on nothing; payload type set by the instantiating module
interface bsf_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/bsf_cfg_regs.sv
// configuration registers and area settings selection
// depends on bsf_pkg
module bsf_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [bsf_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [bsf_pkg::CFG_DATA_W-1:0]  wr_data,
    output bsf_pkg::area_cfg_t              area_cfg
);

    logic                            area_select_reg;
    logic [bsf_pkg::LEN_W-1:0]       address_length_reg;
    logic [bsf_pkg::RAW_W-1:0]       address_sync_reg;
    logic [bsf_pkg::LEN_W-1:0]       data_length_reg;
    logic [bsf_pkg::RAW_W-1:0]       data_sync_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_select_reg    <= 1'b0;
            address_length_reg <= bsf_pkg::RST_ADDRESS_LENGTH;
            address_sync_reg   <= '0;
            data_length_reg    <= bsf_pkg::RST_DATA_LENGTH;
            data_sync_reg      <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                bsf_pkg::CFG_AREA_SELECT:    area_select_reg    <= wr_data[0];
                bsf_pkg::CFG_ADDRESS_LENGTH: address_length_reg <= wr_data[bsf_pkg::LEN_W-1:0];
                bsf_pkg::CFG_ADDRESS_SYNC:   address_sync_reg   <= wr_data[bsf_pkg::RAW_W-1:0];
                bsf_pkg::CFG_DATA_LENGTH:    data_length_reg    <= wr_data[bsf_pkg::LEN_W-1:0];
                bsf_pkg::CFG_DATA_SYNC:      data_sync_reg      <= wr_data[bsf_pkg::RAW_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        area_cfg.length  = area_select_reg ? data_length_reg : address_length_reg;
        area_cfg.pattern = area_select_reg ? data_sync_reg : address_sync_reg;
    end

endmodule

FILE: sv/bsf_hunt.sv
// input register, area state, sync hunt and realignment of one byte per cycle while the result sequencer is free
// depends on bsf_pkg and bsf_stream_if
module bsf_hunt #(
    parameter int MAX_AREA_BYTES = bsf_pkg::DEF_MAX_AREA_BYTES,
    parameter int LENGTH_SLACK   = bsf_pkg::DEF_LENGTH_SLACK
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    bsf_stream_if.sink           byte_stream,
    input  bsf_pkg::area_cfg_t   area_cfg,
    input  logic                 seq_free,
    output logic                 load,
    output bsf_pkg::result_set_t results
);

    localparam int CW = $clog2(MAX_AREA_BYTES);
    localparam int PW = (CW + 3 > bsf_pkg::POS_W) ? CW + 3 : bsf_pkg::POS_W;
    localparam int LW = (CW + 1 > 12) ? CW + 1 : 12;
    localparam logic [CW-1:0] SEEN_MAX = CW'(MAX_AREA_BYTES - 1);
    localparam int EW = bsf_pkg::EMIT_W;

    logic                        s1_valid_reg;
    bsf_pkg::in_item_t           s1_item_reg;
    logic [bsf_pkg::RAW_W-1:0]   prev_byte_reg;
    logic [CW-1:0]               bytes_seen_reg;
    logic                        sync_found_reg;
    logic [2:0]                  sync_shift_reg;
    logic [bsf_pkg::POS_W-1:0]   sync_position_reg;
    logic [EW-1:0]               bytes_emitted_reg;

    logic [bsf_pkg::RAW_W-1:0]   b;
    logic [15:0]                 pair;
    logic [15:0]                 pair_shl;
    logic [bsf_pkg::RAW_W-1:0]   prev_shl;
    logic                        pair_hit;
    logic [2:0]                  pair_shift;
    logic                        use_pair;
    logic                        found_now;
    logic                        found_eff;
    logic [2:0]                  shift_eff;
    logic [PW-1:0]               pos_wide;
    logic [bsf_pkg::POS_W-1:0]   pos_eff;
    logic [EW-1:0]               len_e;
    logic [EW-1:0]               need;
    logic [EW-1:0]               emitted_next;
    logic [LW-1:0]               area_len;
    logic [LW-1:0]               len_l;
    logic                        d0_v;
    logic                        d1_v;
    logic [bsf_pkg::RAW_W-1:0]   d0_byte;
    logic [bsf_pkg::RAW_W-1:0]   d1_byte;
    bsf_pkg::area_status_t       status;
    logic                        advance;

    assign advance = s1_valid_reg && seq_free;
    assign load = advance;
    assign byte_stream.ready = !s1_valid_reg || seq_free;

    // sync hunt
    always_comb
    begin
        b = s1_item_reg.raw_byte;
        pair = {prev_byte_reg, b};
        pair_hit = 1'b0;
        pair_shift = 3'd0;
        for (int s = 7; s >= 1; s--)
        begin
            if (pair[15-s -: 8] == area_cfg.pattern)
            begin
                pair_hit = 1'b1;
                pair_shift = 3'(s);
            end
        end
        use_pair = (bytes_seen_reg != '0) && pair_hit;
        found_now = !sync_found_reg && (use_pair || (b == area_cfg.pattern));
        found_eff = sync_found_reg || found_now;
        shift_eff = sync_found_reg ? sync_shift_reg : (use_pair ? pair_shift : 3'd0);
        if (use_pair)
            pos_wide = PW'({bytes_seen_reg - CW'(1), pair_shift});
        else
            pos_wide = PW'({bytes_seen_reg, 3'd0});
        pos_eff = sync_found_reg ? sync_position_reg : pos_wide[bsf_pkg::POS_W-1:0];
    end

    // realignment and status
    always_comb
    begin
        pair_shl = pair << shift_eff;
        prev_shl = prev_byte_reg << shift_eff;
        len_e = EW'(area_cfg.length);
        d0_v = 1'b0;
        d1_v = 1'b0;
        d0_byte = b;
        d1_byte = pair_shl[7:0];
        emitted_next = bytes_emitted_reg;
        if (found_eff)
        begin
            if (shift_eff == 3'd0)
            begin
                if (bytes_emitted_reg < len_e)
                begin
                    d0_v = 1'b1;
                    emitted_next = bytes_emitted_reg + EW'(1);
                end
            end
            else if (bytes_emitted_reg < len_e)
            begin
                d0_v = 1'b1;
                d0_byte = pair_shl[15:8];
                emitted_next = bytes_emitted_reg + EW'(1);
                if (bytes_emitted_reg + EW'(1) == len_e)
                begin
                    d1_v = 1'b1;
                    emitted_next = bytes_emitted_reg + EW'(2);
                end
            end
            else if (bytes_emitted_reg == len_e)
            begin
                d0_v = 1'b1;
                d0_byte = prev_shl;
                emitted_next = bytes_emitted_reg + EW'(1);
            end
        end

        area_len = LW'(bytes_seen_reg) + LW'(1);
        len_l = LW'(area_cfg.length);
        need = len_e + EW'(found_eff && (shift_eff != 3'd0));
        if ((area_len < len_l) || (area_len > len_l + LW'(LENGTH_SLACK)))
            status = bsf_pkg::ST_LENGTH;
        else if (!found_eff)
            status = bsf_pkg::ST_NO_SYNC;
        else if (emitted_next < need)
            status = bsf_pkg::ST_TOO_LESS;
        else
            status = bsf_pkg::ST_OK;

        results.valid = {s1_item_reg.final_byte, d1_v, d0_v};
        results.item[0] = '{kind: bsf_pkg::KIND_DATA, aligned_byte: d0_byte,
                            area_status: 2'd0, sync_bit_position: '0, run_end: 1'b0};
        results.item[1] = '{kind: bsf_pkg::KIND_DATA, aligned_byte: d1_byte,
                            area_status: 2'd0, sync_bit_position: '0, run_end: 1'b0};
        results.item[2] = '{kind: bsf_pkg::KIND_STATUS, aligned_byte: '0,
                            area_status: status,
                            sync_bit_position: found_eff ? pos_eff : '0,
                            run_end: 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (byte_stream.valid && byte_stream.ready)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (byte_stream.valid && byte_stream.ready)
            s1_item_reg <= byte_stream.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_byte_reg     <= '0;
            bytes_seen_reg    <= '0;
            sync_found_reg    <= 1'b0;
            sync_shift_reg    <= '0;
            sync_position_reg <= '0;
            bytes_emitted_reg <= '0;
        end
        else if (advance)
        begin
            if (s1_item_reg.final_byte)
            begin
                prev_byte_reg     <= '0;
                bytes_seen_reg    <= '0;
                sync_found_reg    <= 1'b0;
                sync_shift_reg    <= '0;
                sync_position_reg <= '0;
                bytes_emitted_reg <= '0;
            end
            else
            begin
                prev_byte_reg <= b;
                if (bytes_seen_reg < SEEN_MAX)
                    bytes_seen_reg <= bytes_seen_reg + CW'(1);
                sync_found_reg    <= found_eff;
                sync_shift_reg    <= found_eff ? shift_eff : 3'd0;
                sync_position_reg <= found_eff ? pos_eff : '0;
                bytes_emitted_reg <= emitted_next;
            end
        end
    end

    a_no_emit_before_sync: assert property (@(posedge clk) disable iff (!rst_n)
        !sync_found_reg |-> (bytes_emitted_reg == '0))
        else $error("bytes emitted without sync");

    a_idle_shift_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !sync_found_reg |-> (sync_shift_reg == 3'd0 && sync_position_reg == '0))
        else $error("sync shift or position held without sync");

    a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_item_reg.final_byte) |=> (bytes_seen_reg == '0 && !sync_found_reg))
        else $error("area state not cleared after final byte");

endmodule

FILE: sv/bsf_out_seq.sv
// result register holding up to three beats of one byte, sent one per cycle while the result stream is ready
// depends on bsf_pkg and bsf_stream_if
module bsf_out_seq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  bsf_pkg::result_set_t results,
    output logic                 seq_free,
    bsf_stream_if.source         result_stream
);

    logic [bsf_pkg::RESULT_SLOTS-1:0]          mask_reg;
    bsf_pkg::out_item_t [bsf_pkg::RESULT_SLOTS-1:0] items_reg;
    logic [1:0]                                sel;
    logic                                      take;

    always_comb
    begin
        if (mask_reg[0])
            sel = 2'd0;
        else if (mask_reg[1])
            sel = 2'd1;
        else
            sel = 2'd2;
    end

    assign result_stream.valid = |mask_reg;
    assign result_stream.data = items_reg[sel];
    assign take = result_stream.valid && result_stream.ready;
    assign seq_free = (mask_reg == '0)
                      || (((mask_reg & (mask_reg - 3'd1)) == '0) && result_stream.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else if (load)
            mask_reg <= results.valid;
        else if (take)
            mask_reg[sel] <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            items_reg <= results.item;
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> seq_free)
        else $error("result register overwritten while beats pending");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_stream.valid && result_stream.data.run_end) |-> (mask_reg[1:0] == 2'b00))
        else $error("status beat ahead of data beats");

endmodule

FILE: sv/bit_aligned_sync_byte_framer.sv
// bit-aligned sync byte framer, top level
// datapath: a byte passes the input register, then the result register, before its first result beat
// throughput: one byte per cycle while each byte yields at most one beat and the result port is ready;
// a byte yielding two or three beats holds the input until only one of its beats is left,
// set by the single-beat result port
// reset: asynchronous, clears area state, pending beats and config to defaults
module bit_aligned_sync_byte_framer #(
    parameter int MAX_AREA_BYTES = bsf_pkg::DEF_MAX_AREA_BYTES,
    parameter int LENGTH_SLACK   = bsf_pkg::DEF_LENGTH_SLACK
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    bsf_stream_if.sink                      byte_stream,
    bsf_stream_if.source                    result_stream,
    input  logic                            wr_en,
    input  logic [bsf_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [bsf_pkg::CFG_DATA_W-1:0]  wr_data
);

    bsf_pkg::area_cfg_t   area_cfg;
    bsf_pkg::result_set_t results;
    logic                 load;
    logic                 seq_free;

    bsf_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .area_cfg (area_cfg)
    );

    bsf_hunt #(
        .MAX_AREA_BYTES (MAX_AREA_BYTES),
        .LENGTH_SLACK   (LENGTH_SLACK)
    ) u_hunt (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .area_cfg    (area_cfg),
        .seq_free    (seq_free),
        .load        (load),
        .results     (results)
    );

    bsf_out_seq u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .results       (results),
        .seq_free      (seq_free),
        .result_stream (result_stream)
    );

endmodule
